// ===== rtl/core/s9dec_pkg.sv =====
// Shared types, constants and selector tables for the Simple9 word decoder.
package s9dec_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VALUE_W = 28;
  localparam int unsigned SEL_W   = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned BITS_W  = 5;

  localparam logic [SEL_W-1:0] SEL_ONES = 4'd9;

  typedef logic [SEL_W-1:0]   sel_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BITS_W-1:0]  bits_t;
  typedef logic [VALUE_W-1:0] value_t;

  // Sequencer to unpack datapath
  typedef struct packed {
    logic load;   // capture a new word
    logic step;   // emit one field and shift
    logic last;   // field being emitted is the word's final one
  } ctrl_t;

  // Number of fields packed under each selector; zero means no packing
  function automatic count_t sel_count(input sel_t sel);
    count_t c;
    case (sel)
      4'd1:    c = 5'd1;
      4'd2:    c = 5'd2;
      4'd3:    c = 5'd3;
      4'd4:    c = 5'd4;
      4'd5:    c = 5'd5;
      4'd6:    c = 5'd7;
      4'd7:    c = 5'd9;
      4'd8:    c = 5'd14;
      4'd9:    c = 5'd28;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // Field width in bits under each selector
  function automatic bits_t sel_bits(input sel_t sel);
    bits_t b;
    case (sel)
      4'd1:    b = 5'd28;
      4'd2:    b = 5'd14;
      4'd3:    b = 5'd9;
      4'd4:    b = 5'd7;
      4'd5:    b = 5'd5;
      4'd6:    b = 5'd4;
      4'd7:    b = 5'd3;
      4'd8:    b = 5'd2;
      4'd9:    b = 5'd1;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

  // Field mask under each selector
  function automatic value_t sel_mask(input sel_t sel);
    value_t m;
    case (sel)
      4'd1:    m = 28'h fffffff;
      4'd2:    m = 28'h0003fff;
      4'd3:    m = 28'h00001ff;
      4'd4:    m = 28'h000007f;
      4'd5:    m = 28'h000001f;
      4'd6:    m = 28'h000000f;
      4'd7:    m = 28'h0000007;
      4'd8:    m = 28'h0000003;
      4'd9:    m = 28'h0000001;
      default: m = 28'h0000000;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/s9dec_if.sv =====
// Valid/ready channel interfaces for packed words and decoded values.
interface s9dec_in_if
  import s9dec_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink   (input valid, input packed_word, output ready);
endinterface

interface s9dec_out_if
  import s9dec_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last_in_word;

  modport source (output valid, output value, output last_in_word, input ready);
  modport sink   (input valid, input value, input last_in_word, output ready);
endinterface

// ===== rtl/core/s9dec_seq.sv =====
// Sequencer: accepts a word, then steps the shared shifter once per field.
module s9dec_seq
  import s9dec_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  sel_t  in_sel,
  input  logic  out_free,
  output logic  in_ready,
  output ctrl_t ctrl
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  count_t remaining_r;
  count_t in_count;

  assign in_count = sel_count(in_sel);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    ctrl.last = (remaining_r == 5'd1);
    case (state_r)
      ST_IDLE: ctrl.load = in_valid && (in_count != 5'd0);
      ST_RUN:  ctrl.step = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remaining_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          // undefined selectors are dropped without output
          if (in_valid && (in_count != 5'd0)) begin
            remaining_r <= in_count;
            state_r     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (out_free) begin
            remaining_r <= remaining_r - 5'd1;
            if (remaining_r == 5'd1) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/s9dec_unpack.sv =====
// Unpack datapath: payload register, shared variable right shifter, output register.
module s9dec_unpack
  import s9dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_t             ctrl,
  input  logic [WORD_W-1:0] in_word,
  input  logic              out_ready,
  output logic              out_valid,
  output value_t            out_value,
  output logic              out_last,
  output logic              out_free
);

  value_t payload_r;
  value_t mask_r;
  bits_t  bits_r;
  logic   ones_r;
  value_t value_r;
  logic   last_r;
  logic   valid_r;
  sel_t   sel;

  assign sel       = in_word[WORD_W-1 -: SEL_W];
  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_last  = last_r;

  // payload and field registers carry no reset
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      payload_r <= in_word[VALUE_W-1:0];
      mask_r    <= sel_mask(sel);
      bits_r    <= sel_bits(sel);
      ones_r    <= (sel == SEL_ONES);
    end else if (ctrl.step) begin
      payload_r <= payload_r >> bits_r;
    end
    if (ctrl.step) begin
      value_r <= ones_r ? value_t'(1) : (payload_r & mask_r);
      last_r  <= ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.step) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/simple9_word_decoder.sv =====
// Simple9 word decoder top level: sequencer plus shared unpack datapath.
//
// Usage:
//   in_ch carries one 32-bit packed word per transfer (bits 31..28 selector,
//   27..0 payload). out_ch carries one decoded value per transfer, least
//   significant field first, with last_in_word set on the word's final value.
//   Selectors 1..9 yield 1,2,3,4,5,7,9,14,28 values; selector 9 yields ones.
//   Selectors 0 and 10..15 are consumed and produce no transfer.
// Timing:
//   A taken word is loaded into the payload register; each field then goes
//   through the shifter into the output register, one value per cycle while
//   out_ch is ready. The single variable shifter steps once per field.
//   in_ch.ready is low while fields remain.
// Stall and reset:
//   When out_ch.ready is low the output register holds and the shifter
//   waits. The next word may be taken while the final value still waits.
//   Synchronous active-low reset returns the sequencer to idle and drops
//   any pending output.
module simple9_word_decoder
  import s9dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  s9dec_in_if.sink           in_ch,
  s9dec_out_if.source        out_ch
);

  ctrl_t ctrl;
  logic  out_free;

  s9dec_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_sel   (in_ch.packed_word[WORD_W-1 -: SEL_W]),
    .out_free (out_free),
    .in_ready (in_ch.ready),
    .ctrl     (ctrl)
  );

  s9dec_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_word   (in_ch.packed_word),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_value (out_ch.value),
    .out_last  (out_ch.last_in_word),
    .out_free  (out_free)
  );

endmodule

// ===== tb/sv/simple9_word_decoder_test.sv =====
// Self-checking testbench for the Simple9 word decoder: directed words, then random traffic.
module simple9_word_decoder_test
  import s9dec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 340;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned NUM_ROWS     = 25;

  localparam sel_t SEL_NONE         = 4'd0;
  localparam sel_t SEL_FIRST_UNUSED = 4'd10;

  // Values per word and bits per value, indexed by selector
  localparam int unsigned FIELDS_PER_SEL [16] =
    '{0, 1, 2, 3, 4, 5, 7, 9, 14, 28, 0, 0, 0, 0, 0, 0};
  localparam int unsigned FIELD_WIDTH [16] =
    '{0, 28, 14, 9, 7, 5, 4, 3, 2, 1, 0, 0, 0, 0, 0, 0};

  typedef struct {
    value_t value;
    logic   last;
  } decoded_t;

  // typed rows: count copies of fill; otherwise the unpacker decides
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              typed;
    logic [4:0]        count;
    value_t            fill;
  } word_row_t;

  localparam word_row_t WORD_ROWS [NUM_ROWS] = '{
    '{32'h0000_0000, 1'b1, 5'd0,  28'h0000000},
    '{32'h0FFF_FFFF, 1'b1, 5'd0,  28'h0000000},
    '{32'h1000_0000, 1'b1, 5'd1,  28'h0000000},
    '{32'h1FFF_FFFF, 1'b1, 5'd1,  28'hfffffff},
    '{32'h2FFF_FFFF, 1'b1, 5'd2,  28'h0003fff},
    '{32'h3FFF_FFFF, 1'b1, 5'd3,  28'h00001ff},
    '{32'h4FFF_FFFF, 1'b1, 5'd4,  28'h000007f},
    '{32'h5FFF_FFFF, 1'b1, 5'd5,  28'h000001f},
    '{32'h6FFF_FFFF, 1'b1, 5'd7,  28'h000000f},
    '{32'h7FFF_FFFF, 1'b1, 5'd9,  28'h0000007},
    '{32'h8FFF_FFFF, 1'b1, 5'd14, 28'h0000003},
    '{32'h8000_0000, 1'b1, 5'd14, 28'h0000000},
    '{32'h9000_0000, 1'b1, 5'd28, 28'h0000001},
    '{32'h9FFF_FFFF, 1'b1, 5'd28, 28'h0000001},
    '{32'hAFFF_FFFF, 1'b1, 5'd0,  28'h0000000},
    '{32'hB000_0000, 1'b1, 5'd0,  28'h0000000},
    '{32'hC5A5_A5A5, 1'b1, 5'd0,  28'h0000000},
    '{32'hDFFF_FFFF, 1'b1, 5'd0,  28'h0000000},
    '{32'hE000_0001, 1'b1, 5'd0,  28'h0000000},
    '{32'hFFFF_FFFF, 1'b1, 5'd0,  28'h0000000},
    '{32'h2ABC_1234, 1'b0, 5'd0,  28'h0000000},
    '{32'h5E0F_7C21, 1'b0, 5'd0,  28'h0000000},
    '{32'h7876_5432, 1'b0, 5'd0,  28'h0000000},
    '{32'h3DEA_DBEE, 1'b0, 5'd0,  28'h0000000},
    '{32'h6123_ABCD, 1'b0, 5'd0,  28'h0000000}
  };

  logic clk = 1'b0;
  logic rst_n;

  s9dec_in_if  in_ch ();
  s9dec_out_if out_ch ();

  simple9_word_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decoded_t    pending_values[$];
  int unsigned mismatches    = 0;
  int unsigned values_seen   = 0;
  int unsigned stuck_cycles  = 0;
  logic        steady_in     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected values for one accepted word, least significant field first
  function automatic void unpack_word(input logic [WORD_W-1:0] word);
    sel_t        sel;
    int unsigned n;
    int unsigned width;
    logic [31:0] payload;
    logic [31:0] mask;
    decoded_t    d;
    sel     = word[WORD_W-1 -: SEL_W];
    n       = FIELDS_PER_SEL[sel];
    width   = FIELD_WIDTH[sel];
    payload = {4'h0, word[VALUE_W-1:0]};
    mask    = (32'd1 << width) - 32'd1;
    for (int unsigned k = 0; k < n; k++) begin
      if (sel == SEL_ONES) d.value = value_t'(1);
      else d.value = value_t'((payload >> (width * k)) & mask);
      d.last = (k + 1 == n);
      pending_values.push_back(d);
    end
  endfunction

  function automatic void push_typed(input logic [4:0] count, input value_t fill);
    decoded_t d;
    for (int unsigned k = 0; k < count; k++) begin
      d.value = fill;
      d.last  = (k + 1 == count);
      pending_values.push_back(d);
    end
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    sel_t         sel;
    logic [27:0]  payload;
    int unsigned  pick;
    if ($urandom_range(99) < 12) begin
      pick = $urandom_range(6);
      sel  = (pick == 0) ? SEL_NONE : sel_t'(SEL_FIRST_UNUSED + pick - 1);
    end else begin
      sel = sel_t'($urandom_range(9, 1));
    end
    case ($urandom_range(9))
      0:       payload = '0;
      1:       payload = '1;
      2:       payload = 28'd1 << $urandom_range(27);
      3:       payload = ~(28'd1 << $urandom_range(27));
      default: payload = 28'($urandom());
    endcase
    return {sel, payload};
  endfunction

  // Offer one word, with random idle cycles first unless steady_in is set; expectations are queued on transfer
  task automatic send_word(input logic [WORD_W-1:0] word, input logic typed,
                           input logic [4:0] count, input value_t fill);
    while (!steady_in && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.packed_word <= word;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) push_typed(count, fill);
    else unpack_word(word);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, what);
  endtask

  // Result checker
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      values_seen++;
      if (pending_values.size() == 0) begin
        note_mismatch($sformatf("unexpected value %h last %b",
                                out_ch.value, out_ch.last_in_word));
      end else begin
        want = pending_values.pop_front();
        if (out_ch.value !== want.value || out_ch.last_in_word !== want.last)
          note_mismatch($sformatf("value exp %h got %h, last exp %b got %b",
                                  want.value, out_ch.value, want.last,
                                  out_ch.last_in_word));
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin : receiver
    logic long_hold_done;
    long_hold_done = 1'b0;
    out_ch.ready   = 1'b0;
    @(posedge clk);
    forever begin
      if (!long_hold_done && values_seen >= 300) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ch.ready <= (values_seen >= 1000 && values_seen < 1600) ||
                        ($urandom_range(99) >= 7);
        @(posedge clk);
      end
    end
  end

  initial begin : sender
    int unsigned      words_sent;
    logic [WORD_W-1:0] word;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.packed_word = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int unsigned r = 0; r < NUM_ROWS; r++)
      send_word(WORD_ROWS[r].word, WORD_ROWS[r].typed, WORD_ROWS[r].count,
                WORD_ROWS[r].fill);

    // ignored selectors do not count toward the random total
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent == 100) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_values.size() != 0);
      end
      steady_in = (words_sent >= 150 && words_sent < 250);
      word = random_word();
      send_word(word, 1'b0, 5'd0, '0);
      if (FIELDS_PER_SEL[word[WORD_W-1 -: SEL_W]] != 0) words_sent++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_values.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== simple9_word_decoder.f =====
rtl/core/s9dec_pkg.sv
rtl/core/s9dec_if.sv
rtl/core/s9dec_seq.sv
rtl/core/s9dec_unpack.sv
rtl/core/simple9_word_decoder.sv
tb/sv/simple9_word_decoder_test.sv
